// ===== hdl/mbd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants for the button debounce block
// Sizes of the expander bank, opcode and mode codes, register indexes, and
// the structures passed between the top level, the pin lanes and the merge.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int NUM_EXPANDERS     = 4;
  localparam int PINS_PER_EXPANDER = 16;
  localparam int TIME_WIDTH        = 32;

  localparam int NUM_CHANNELS  = NUM_EXPANDERS * PINS_PER_EXPANDER;
  localparam int EXP_IDX_W     = (NUM_EXPANDERS > 1) ? $clog2(NUM_EXPANDERS) : 1;
  localparam int PIN_IDX_W     = $clog2(PINS_PER_EXPANDER);
  localparam int WORD_W        = 16;
  localparam int COUNT_W       = 32;
  localparam int DEBOUNCE_W    = 32;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int MODE_CHANNELS = 64;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_FALL = 2'd0,
    MODE_RISE = 2'd1,
    MODE_BOTH = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_HIGH = 2'd2;

  typedef struct packed {
    logic                  sample;
    logic                  clear;
    logic [EXP_IDX_W-1:0]  entry;
    logic                  level;
    logic [TIME_WIDTH-1:0] now;
    logic [DEBOUNCE_W-1:0] debounce;
  } lane_cmd_t;

  typedef struct packed {
    logic               steady;
    logic               pressed;
    logic               released;
    logic [COUNT_W-1:0] count;
  } lane_res_t;

  typedef struct packed {
    logic                 sample_ok;
    logic                 read_ok;
    logic [PIN_IDX_W-1:0] read_lane;
  } op_info_t;

  typedef struct packed {
    logic [WORD_W-1:0]  steady_word;
    logic [WORD_W-1:0]  pressed_mask;
    logic [WORD_W-1:0]  released_mask;
    logic [COUNT_W-1:0] count_value;
  } out_rec_t;

  typedef struct packed {
    logic [EXP_IDX_W-1:0] entry;
    logic [PIN_IDX_W-1:0] lane;
  } chan_loc_t;

  // Splits a channel number into expander entry and pin lane.
  function automatic chan_loc_t chan_split(input logic [5:0] ch);
    chan_loc_t  loc;
    logic [8:0] base;
    loc.entry = '0;
    loc.lane  = '0;
    for (int e = 0; e < NUM_EXPANDERS; e++) begin
      base = 9'(e * PINS_PER_EXPANDER);
      if (9'(ch) >= base) begin
        loc.entry = EXP_IDX_W'(e);
        loc.lane  = PIN_IDX_W'(9'(ch) - base);
      end
    end
    return loc;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mbd_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_lane: debounce and edge count for one pin position
// Holds the state of this pin on every expander and updates the entry of the
// expander that the current beat addresses.
// ----------------------------------------------------------------------------
module mbd_lane
  import mbd_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire lane_cmd_t                       cmd,
  input  wire logic [NUM_EXPANDERS-1:0][1:0]   modes,
  output lane_res_t                            res
);

  logic                  raw_r    [NUM_EXPANDERS];
  logic                  steady_r [NUM_EXPANDERS];
  logic [TIME_WIDTH-1:0] ct_r     [NUM_EXPANDERS];
  logic [COUNT_W-1:0]    cnt_r    [NUM_EXPANDERS];

  logic                  changed;
  logic [TIME_WIDTH-1:0] ct_nxt;
  logic [TIME_WIDTH-1:0] held;
  logic                  prev;
  logic                  steady_nxt;
  logic                  count_it;
  logic [COUNT_W-1:0]    cnt_nxt;
  mode_t                 mode;

  always_comb begin
    changed    = cmd.level != raw_r[cmd.entry];
    ct_nxt     = changed ? cmd.now : ct_r[cmd.entry];
    held       = cmd.now - ct_nxt;
    prev       = steady_r[cmd.entry];
    steady_nxt = (DEBOUNCE_W'(held) >= cmd.debounce) ? cmd.level : prev;
    mode       = mode_t'(modes[cmd.entry]);
    count_it   = 1'b0;
    if (prev != steady_nxt) begin
      unique case (mode)
        MODE_FALL: count_it = prev;
        MODE_RISE: count_it = ~prev;
        MODE_BOTH: count_it = 1'b1;
        MODE_NONE: count_it = 1'b0;
        default:   count_it = 1'b0;
      endcase
    end
    cnt_nxt      = cnt_r[cmd.entry] + COUNT_W'(1);
    res.steady   = steady_nxt;
    res.pressed  = prev & ~steady_nxt;
    res.released = ~prev & steady_nxt;
    res.count    = cnt_r[cmd.entry];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < NUM_EXPANDERS; e++) begin
        raw_r[e]    <= 1'b1;
        steady_r[e] <= 1'b1;
        ct_r[e]     <= '0;
        cnt_r[e]    <= '0;
      end
    end else if (cmd.sample) begin
      raw_r[cmd.entry]    <= cmd.level;
      ct_r[cmd.entry]     <= ct_nxt;
      steady_r[cmd.entry] <= steady_nxt;
      if (count_it) begin
        cnt_r[cmd.entry] <= cnt_nxt;
      end
    end else if (cmd.clear) begin
      cnt_r[cmd.entry] <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mbd_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_merge: combines the lane results into one result beat
// Packs the per-pin bits into words, picks the addressed count, and holds
// results in a two-entry output buffer so that intake goes on under stall.
// ----------------------------------------------------------------------------
module mbd_merge
  import mbd_pkg::*;
(
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire op_info_t                          info,
  input  wire lane_res_t [PINS_PER_EXPANDER-1:0] lane_res,
  input  wire logic                              out_stall,
  output logic                                   busy,
  output logic                                   out_valid,
  output logic [WORD_W-1:0]                      out_steady_word,
  output logic [WORD_W-1:0]                      out_pressed_mask,
  output logic [WORD_W-1:0]                      out_released_mask,
  output logic [COUNT_W-1:0]                     out_count_value
);

  out_rec_t rec;
  logic [WORD_W-1:0] steady_bits;
  logic [WORD_W-1:0] pressed_bits;
  logic [WORD_W-1:0] released_bits;

  out_rec_t out_data_r, out_data_nxt;
  out_rec_t skid_data_r, skid_data_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;

  // Only pins 0 to 15 appear in the result words.
  for (genvar b = 0; b < WORD_W; b++) begin : g_bits
    if (b < PINS_PER_EXPANDER) begin : g_pin
      assign steady_bits[b]   = lane_res[b].steady;
      assign pressed_bits[b]  = lane_res[b].pressed;
      assign released_bits[b] = lane_res[b].released;
    end else begin : g_none
      assign steady_bits[b]   = 1'b0;
      assign pressed_bits[b]  = 1'b0;
      assign released_bits[b] = 1'b0;
    end
  end

  always_comb begin
    rec.steady_word   = info.sample_ok ? steady_bits : '0;
    rec.pressed_mask  = info.sample_ok ? pressed_bits : '0;
    rec.released_mask = info.sample_ok ? released_bits : '0;
    rec.count_value   = info.read_ok ? lane_res[info.read_lane].count : '0;
  end

  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      // Output slot is free this cycle: the older beat moves up first.
      out_valid_nxt  = skid_valid_r | accept;
      out_data_nxt   = skid_valid_r ? skid_data_r : rec;
      skid_valid_nxt = 1'b0;
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign busy              = skid_valid_r;
  assign out_valid         = out_valid_r;
  assign out_steady_word   = out_data_r.steady_word;
  assign out_pressed_mask  = out_data_r.pressed_mask;
  assign out_released_mask = out_data_r.released_mask;
  assign out_count_value   = out_data_r.count_value;

endmodule
`default_nettype wire

// ===== hdl/multi_button_debounce_edge_counter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_button_debounce_edge_counter: debounce and edge counting for buttons
// Top level: configuration registers, sixteen pin lanes and the merge stage.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while in_stall is low and returns
// one result beat for each from a registered output slot. Sixteen
// pin lanes work side by side on the sampled expander word; each lane keeps
// the timer, levels and 32-bit edge count of its pin on all four expanders
// and updates them in the cycle the beat is taken, so a following beat sees
// the new state at once. A two-entry output buffer keeps intake open for one
// more beat while a result waits; in_stall rises only when both entries are
// full. Count reads and clears address a channel as expander * 16 + pin.
// Configuration may only be written while no result is outstanding.
// ----------------------------------------------------------------------------
module multi_button_debounce_edge_counter
  import mbd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [1:0]            in_expander,
  input  wire logic [15:0]           in_gpio_word,
  input  wire logic [31:0]           in_now_ms,
  input  wire logic [5:0]            in_channel,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WORD_W-1:0]          out_steady_word,
  output logic [WORD_W-1:0]          out_pressed_mask,
  output logic [WORD_W-1:0]          out_released_mask,
  output logic [COUNT_W-1:0]         out_count_value
);

  logic [DEBOUNCE_W-1:0]  debounce_r;
  logic [CFG_DATA_W-1:0]  mode_low_r;
  logic [CFG_DATA_W-1:0]  mode_high_r;
  logic [2*CFG_DATA_W-1:0] mode_all;

  logic                  accept;
  op_t                   op;
  logic                  exp_ok;
  logic                  ch_ok;
  logic [7:0]            exp_ext;
  chan_loc_t             loc;
  logic                  sample_go;
  logic                  clear_go;
  logic [EXP_IDX_W-1:0]  entry;
  op_info_t              info;

  lane_cmd_t [PINS_PER_EXPANDER-1:0]                       lane_cmd;
  lane_res_t [PINS_PER_EXPANDER-1:0]                       lane_res;
  logic      [PINS_PER_EXPANDER-1:0][NUM_EXPANDERS-1:0][1:0] lane_mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= '0;
      mode_low_r  <= '0;
      mode_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  debounce_r  <= cfg_data[DEBOUNCE_W-1:0];
        CFG_MODE_LOW:  mode_low_r  <= cfg_data;
        CFG_MODE_HIGH: mode_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mode_all = {mode_high_r, mode_low_r};

  always_comb begin
    accept    = in_valid & ~in_stall;
    op        = op_t'(in_opcode);
    exp_ext   = 8'(in_expander);
    exp_ok    = exp_ext < 8'(NUM_EXPANDERS);
    ch_ok     = 9'(in_channel) < 9'(NUM_CHANNELS);
    loc       = chan_split(in_channel);
    sample_go = accept & (op == OP_SAMPLE) & exp_ok;
    clear_go  = accept & (op == OP_CLEAR) & ch_ok;
    entry     = (op == OP_SAMPLE) ? exp_ext[EXP_IDX_W-1:0] : loc.entry;
    info.sample_ok = (op == OP_SAMPLE) & exp_ok;
    info.read_ok   = (op == OP_READ) & ch_ok;
    info.read_lane = loc.lane;
  end

  for (genvar p = 0; p < PINS_PER_EXPANDER; p++) begin : g_lane
    always_comb begin
      lane_cmd[p].sample   = sample_go;
      lane_cmd[p].clear    = clear_go & (loc.lane == PIN_IDX_W'(p));
      lane_cmd[p].entry    = entry;
      lane_cmd[p].now      = in_now_ms[TIME_WIDTH-1:0];
      lane_cmd[p].debounce = debounce_r;
    end

    // Pins beyond the sixteen-bit word always read as a low level.
    if (p < 16) begin : g_lvl
      assign lane_cmd[p].level = in_gpio_word[p];
    end else begin : g_zero
      assign lane_cmd[p].level = 1'b0;
    end

    // Channels past the mode registers count falling edges.
    for (genvar e = 0; e < NUM_EXPANDERS; e++) begin : g_mode
      localparam int CH = e * PINS_PER_EXPANDER + p;
      if (CH < MODE_CHANNELS) begin : g_cfg
        assign lane_mode[p][e] = mode_all[2*CH +: 2];
      end else begin : g_dflt
        assign lane_mode[p][e] = MODE_FALL;
      end
    end

    mbd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (lane_cmd[p]),
      .modes (lane_mode[p]),
      .res   (lane_res[p])
    );
  end

  mbd_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .info              (info),
    .lane_res          (lane_res),
    .out_stall         (out_stall),
    .busy              (in_stall),
    .out_valid         (out_valid),
    .out_steady_word   (out_steady_word),
    .out_pressed_mask  (out_pressed_mask),
    .out_released_mask (out_released_mask),
    .out_count_value   (out_count_value)
  );

  // Intake only closes while a result is already waiting at the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_press_release_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pressed_mask & out_released_mask) == '0))
    else $error("pin both pressed and released in one beat");

  a_masks_follow_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_pressed_mask & out_steady_word) == '0) &&
                   ((out_released_mask & ~out_steady_word) == '0)))
    else $error("edge mask disagrees with steady word");

  a_count_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_count_value != '0)) |->
      ((out_steady_word == '0) && (out_pressed_mask == '0) &&
       (out_released_mask == '0)))
    else $error("count returned together with sample fields");

endmodule
`default_nettype wire

// ===== tb/sv/multi_button_debounce_edge_counter_test.sv =====
// ----------------------------------------------------------------------------
// multi_button_debounce_edge_counter_test: self-checking bench for the debouncer
// Sample, read, clear and unused beats go through a queue-fed driver. Each
// accepted beat is run through a cycle-free model of the 64 debounced
// channels and their edge counters, and every result beat is compared field
// by field with the oldest prediction. Phases change the hold time, the count
// modes and the amount of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module multi_button_debounce_edge_counter_test;
  import mbd_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  expander;
    logic [15:0] gpio;
    logic [31:0] now;
    logic [5:0]  chan;
  } button_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_opcode = '0;
  logic [1:0]            in_expander = '0;
  logic [15:0]           in_gpio_word = '0;
  logic [31:0]           in_now_ms = '0;
  logic [5:0]            in_channel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WORD_W-1:0]     out_steady_word;
  logic [WORD_W-1:0]     out_pressed_mask;
  logic [WORD_W-1:0]     out_released_mask;
  logic [COUNT_W-1:0]    out_count_value;

  multi_button_debounce_edge_counter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_expander      (in_expander),
    .in_gpio_word     (in_gpio_word),
    .in_now_ms        (in_now_ms),
    .in_channel       (in_channel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_steady_word  (out_steady_word),
    .out_pressed_mask (out_pressed_mask),
    .out_released_mask(out_released_mask),
    .out_count_value  (out_count_value)
  );

  always #5 clk = ~clk;

  // Model copy of the registers and of the per-channel state.
  logic [DEBOUNCE_W-1:0] hold_ms = '0;
  logic [63:0]           mode_lo = '0;
  logic [63:0]           mode_hi = '0;
  logic                  raw_lvl [NUM_CHANNELS] = '{default: 1'b1};
  logic                  stable_lvl [NUM_CHANNELS] = '{default: 1'b1};
  logic [TIME_WIDTH-1:0] changed_at [NUM_CHANNELS] = '{default: '0};
  logic [COUNT_W-1:0]    edge_total [NUM_CHANNELS] = '{default: '0};

  button_beat_t pending_beats[$];
  out_rec_t     predicted[$];
  int           beats_in = 0;
  int           results_out = 0;
  int           errors = 0;
  int           cycles = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  logic         in_taken = 1'b0;
  logic         hold_req = 1'b0;
  logic         hold_used = 1'b0;
  int           hold_left = 0;

  // Stimulus shaping: a free-running millisecond clock and the intended
  // button levels of each expander, on top of which the bounce is laid.
  logic [31:0]  ms_clock = '0;
  logic [15:0]  intended [NUM_EXPANDERS] = '{default: 16'hFFFF};

  function automatic out_rec_t debounce_step(input button_beat_t b);
    out_rec_t              r;
    int                    c;
    logic                  lvl;
    logic                  was;
    logic [TIME_WIDTH-1:0] held;
    mode_t                 m;
    r = '0;
    case (b.op)
      OP_SAMPLE: begin
        if (int'(b.expander) < NUM_EXPANDERS) begin
          for (int p = 0; p < PINS_PER_EXPANDER; p++) begin
            c   = int'(b.expander) * PINS_PER_EXPANDER + p;
            lvl = (p < WORD_W) ? b.gpio[p] : 1'b0;
            if (lvl != raw_lvl[c]) begin
              changed_at[c] = TIME_WIDTH'(b.now);
              raw_lvl[c]    = lvl;
            end
            was  = stable_lvl[c];
            held = TIME_WIDTH'(b.now) - changed_at[c];
            if (DEBOUNCE_W'(held) >= hold_ms) stable_lvl[c] = lvl;
            if (was != stable_lvl[c]) begin
              if (c < 32) m = mode_t'(mode_lo[2*c +: 2]);
              else if (c < MODE_CHANNELS) m = mode_t'(mode_hi[2*(c-32) +: 2]);
              else m = MODE_FALL;
              if (m == MODE_BOTH || (m == MODE_FALL && was) || (m == MODE_RISE && !was))
                edge_total[c] = edge_total[c] + 1'b1;
            end
            if (p < WORD_W) begin
              r.steady_word[p]   = stable_lvl[c];
              r.pressed_mask[p]  = was && !stable_lvl[c];
              r.released_mask[p] = !was && stable_lvl[c];
            end
          end
        end
      end
      OP_READ: begin
        if (int'(b.chan) < NUM_CHANNELS) r.count_value = edge_total[b.chan];
      end
      OP_CLEAR: begin
        if (int'(b.chan) < NUM_CHANNELS) edge_total[b.chan] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic button_beat_t random_beat();
    button_beat_t b;
    int           pick;
    int           e;
    pick       = $urandom_range(99);
    b.op       = (pick < 74) ? OP_SAMPLE : (pick < 86) ? OP_READ :
                 (pick < 95) ? OP_CLEAR : OP_UNUSED;
    b.expander = 2'($urandom);
    b.gpio     = 16'($urandom);
    b.now      = $urandom;
    b.chan     = 6'($urandom);
    if (b.op == OP_SAMPLE) begin
      pick = $urandom_range(99);
      if (pick < 70) ms_clock += $urandom_range(0, 4);
      else if (pick < 90)
        ms_clock += $urandom_range(0, (hold_ms > 5000) ? 10000 : 2 * hold_ms + 2);
      else if (pick < 95) ms_clock = $urandom;
      else ms_clock -= $urandom_range(1, 3);
      b.now = ms_clock;
      e     = int'(b.expander);
      // Occasional real press or release, then bounce on a few pins.
      if ($urandom_range(99) < 12) intended[e] ^= 16'($urandom & $urandom & $urandom);
      b.gpio = intended[e];
      if ($urandom_range(99) < 30) b.gpio ^= 16'($urandom & $urandom & $urandom);
      if ($urandom_range(99) < 3) b.gpio = 16'($urandom);
    end
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic queue_beat(input logic [1:0] op, input logic [1:0] ex,
                            input logic [15:0] word, input logic [31:0] now,
                            input logic [5:0] ch);
    pending_beats.push_back('{op: op, expander: ex, gpio: word, now: now, chan: ch});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_DEBOUNCE:  hold_ms = val[DEBOUNCE_W-1:0];
      CFG_MODE_LOW:  mode_lo = val;
      CFG_MODE_HIGH: mode_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Returns at a rising edge once every accepted beat has its result back.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || beats_in != results_out);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n,
                           input logic [31:0] hold, input logic [63:0] lo,
                           input logic [63:0] hi, input logic with_hold);
    wait_drained();
    idle_pct  = idle;
    stall_pct = stall;
    write_reg(CFG_DEBOUNCE, {32'd0, hold});
    write_reg(CFG_MODE_LOW, lo);
    write_reg(CFG_MODE_HIGH, hi);
    if (with_hold) hold_req = 1'b1;
    @(posedge clk);
    if (with_hold) begin
      for (int i = 0; i < n / 2; i++) pending_beats.push_back(random_beat());
      // The sender pauses here until the block has handed back everything.
      wait_drained();
      for (int i = n / 2; i < n; i++) pending_beats.push_back(random_beat());
    end else begin
      for (int i = 0; i < n; i++) pending_beats.push_back(random_beat());
    end
  endtask

  // Sender: a beat stays on the bus until it has been taken.
  always @(negedge clk) begin : driver
    button_beat_t b;
    if (!in_valid || in_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
        b = pending_beats.pop_front();
        in_valid     <= 1'b1;
        in_opcode    <= b.op;
        in_expander  <= b.expander;
        in_gpio_word <= b.gpio;
        in_now_ms    <= b.now;
        in_channel   <= b.chan;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps offering beats.
  always @(posedge clk) begin : hold_off
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    out_rec_t     got;
    out_rec_t     want;
    button_beat_t b;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      b = '{op: in_opcode, expander: in_expander, gpio: in_gpio_word,
            now: in_now_ms, chan: in_channel};
      predicted.push_back(debounce_step(b));
      beats_in <= beats_in + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{steady_word: out_steady_word, pressed_mask: out_pressed_mask,
              released_mask: out_released_mask, count_value: out_count_value};
      if (predicted.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", got.count_value, '0);
      end else begin
        want = predicted.pop_front();
        if (got.steady_word !== want.steady_word)
          report_mismatch("steady_word", got.steady_word, want.steady_word);
        if (got.pressed_mask !== want.pressed_mask)
          report_mismatch("pressed_mask", got.pressed_mask, want.pressed_mask);
        if (got.released_mask !== want.released_mask)
          report_mismatch("released_mask", got.released_mask, want.released_mask);
        if (got.count_value !== want.count_value)
          report_mismatch("count_value", got.count_value, want.count_value);
      end
      results_out <= results_out + 1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multi_button_debounce_edge_counter_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero hold time, every channel counts falling edges.
    queue_beat(OP_SAMPLE, 2'd0, 16'hFFFF, 32'd0, 6'd0);
    queue_beat(OP_SAMPLE, 2'd0, 16'h0000, 32'd1, 6'd0);
    queue_beat(OP_SAMPLE, 2'd0, 16'h0000, 32'd2, 6'd0);
    queue_beat(OP_SAMPLE, 2'd1, 16'hA5A5, 32'd3, 6'd0);
    queue_beat(OP_SAMPLE, 2'd3, 16'h0000, 32'd4, 6'd0);
    queue_beat(OP_SAMPLE, 2'd3, 16'hFFFF, 32'd5, 6'd0);
    queue_beat(OP_SAMPLE, 2'd2, 16'h8001, 32'hFFFF_FFFF, 6'd0);
    queue_beat(OP_READ, 2'd0, 16'h0000, 32'd0, 6'd0);
    queue_beat(OP_READ, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    queue_beat(OP_CLEAR, 2'd0, 16'h0000, 32'd0, 6'd0);
    queue_beat(OP_READ, 2'd0, 16'h0000, 32'd0, 6'd0);
    queue_beat(OP_UNUSED, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 6'd63);
    queue_beat(OP_SAMPLE, 2'd0, 16'hFFFF, 32'd0, 6'd0);
    queue_beat(OP_READ, 2'd1, 16'h0000, 32'd0, 6'd17);
    wait_drained();

    // Largest hold time: only a full wrap-around of the timer lets a level in.
    write_reg(CFG_DEBOUNCE, 64'hFFFF_FFFF);
    write_reg(CFG_MODE_LOW, '1);
    write_reg(CFG_MODE_HIGH, {32{2'(MODE_BOTH)}});
    @(posedge clk);
    queue_beat(OP_SAMPLE, 2'd0, 16'h0000, 32'd100, 6'd0);
    queue_beat(OP_SAMPLE, 2'd0, 16'h0000, 32'd99, 6'd0);
    queue_beat(OP_READ, 2'd0, 16'h0000, 32'd0, 6'd0);
    queue_beat(OP_SAMPLE, 2'd3, 16'h0000, 32'd50, 6'd0);
    queue_beat(OP_SAMPLE, 2'd3, 16'h0000, 32'd49, 6'd0);
    queue_beat(OP_READ, 2'd0, 16'h0000, 32'd0, 6'd63);
    queue_beat(OP_CLEAR, 2'd0, 16'h0000, 32'd0, 6'd63);
    queue_beat(OP_READ, 2'd0, 16'h0000, 32'd0, 6'd63);

    run_phase(0, 0, 260, 32'd3, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    run_phase(86, 0, 220, 32'd6, '0, '1, 1'b0);
    run_phase(0, 86, 220, 32'd1, {32{2'(MODE_BOTH)}}, {32{2'(MODE_RISE)}}, 1'b0);
    run_phase(33, 33, 260, $urandom_range(0, 12), {$urandom, $urandom},
              {$urandom, $urandom}, 1'b0);
    run_phase(0, 0, 200, 32'd0, '1, {$urandom, $urandom}, 1'b1);
    run_phase(33, 33, 150, 32'hFFFF_FFFE, {$urandom, $urandom},
              {$urandom, $urandom}, 1'b0);
    wait_drained();

    if (predicted.size() != 0)
      report_mismatch("results never delivered", predicted.size(), '0);
    if (errors == 0) begin
      $display("multi_button_debounce_edge_counter_test: clean");
    end else begin
      $display("multi_button_debounce_edge_counter_test: errors");
    end
    $finish;
  end

endmodule
